[rtl/ksu_pkg.sv]
// ksu_pkg: shared constants for the keyword spotter.
// Fixed keyword table, config register indexes, ASCII folding constants.
// No dependencies.
package ksu_pkg;

  localparam int FIXED_COUNT = 10;
  localparam int FIXED_MAX   = 12;   // longest fixed keyword, bytes
  localparam int EXTRA_MAX   = 16;   // longest extra keyword, bytes

  // Config register indexes
  localparam logic [1:0] CFG_EXTRA_LOW  = 2'd0;
  localparam logic [1:0] CFG_EXTRA_HIGH = 2'd1;
  localparam logic [1:0] CFG_EXTRA_LEN  = 2'd2;

  // ASCII case folding
  localparam logic [7:0] ASCII_UPPER_A = 8'h41;
  localparam logic [7:0] ASCII_UPPER_Z = 8'h5A;
  localparam logic [7:0] ASCII_CASE    = 8'h20;

  // Keyword bytes, first byte in bits 7:0; ASCII ones stored lower case.
  localparam logic [FIXED_MAX*8-1:0] FIXED_WORDS [FIXED_COUNT] = '{
    96'h0000_0000_0000_0000_6564_6F63,  // code
    96'h0000_0000_0000_0000_0070_746F,  // otp
    96'h0000_0000_0000_7966_6972_6576,  // verify
    96'h6E6F_6974_6163_6966_6972_6576,  // verification
    96'h0000_0000_0000_0000_006E_6970,  // pin
    96'h0000_0000_6472_6F77_7373_6170,  // password
    96'h0000_0000_0000_6477_7373_6170,  // passwd
    96'h0000_0081_A0E7_81AF_E88C_AAE9,  // CJK "verification code"
    96'h0000_0081_A0E7_8CAA_E9A1_A0E6,  // CJK "check code"
    96'h0000_0081_A0E7_8180_E6A8_8AE5   // CJK "dynamic code"
  };

  localparam logic [3:0] FIXED_LENS [FIXED_COUNT] = '{
    4'd4, 4'd3, 4'd6, 4'd12, 4'd3, 4'd8, 4'd6, 4'd9, 4'd9, 4'd9
  };

  // bit k set: keyword k is pure ASCII and matched case-insensitively
  localparam logic [FIXED_COUNT-1:0] FIXED_FOLD = 10'b00_0111_1111;

endpackage

[rtl/keyword_spotter_unit.sv]
// keyword_spotter_unit: streaming keyword detector, top level.
// Depends on ksu_pkg (keyword table, register indexes).
//
// Pipeline: a byte is matched from the input register and, if it ends a
//   message, its result beat is then loaded into the result register.
// Throughput: one byte per cycle; the input register and the result
//   register decouple the sides, only a stalled pending result holds input.
// Reset (rst_ni low, async): window, found flag, pipeline valids and the
//   extra keyword registers all clear; the extra keyword starts disabled.
module keyword_spotter_unit #(
  parameter int WINDOW_BYTES = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // byte stream in
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  text_byte_i,
  input  logic        last_byte_i,
  // result out
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic        keyword_found_o,
  // config writes
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [63:0] cfg_data_i
);

  localparam int XMAX = ksu_pkg::EXTRA_MAX;
  localparam int FCNT = ksu_pkg::FIXED_COUNT;
  localparam int FMAX = ksu_pkg::FIXED_MAX;

  function automatic logic [7:0] fold_byte(input logic [7:0] c);
    if (c >= ksu_pkg::ASCII_UPPER_A && c <= ksu_pkg::ASCII_UPPER_Z) begin
      return c + ksu_pkg::ASCII_CASE;
    end
    return c;
  endfunction

  // ---------------------------------------------------------------------------
  // Config registers. Writes always complete.
  // ---------------------------------------------------------------------------
  logic [63:0] xlow_q, xhigh_q;
  logic [4:0]  xlen_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      xlow_q  <= '0;
      xhigh_q <= '0;
      xlen_q  <= '0;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        ksu_pkg::CFG_EXTRA_LOW:  xlow_q  <= cfg_data_i;
        ksu_pkg::CFG_EXTRA_HIGH: xhigh_q <= cfg_data_i;
        ksu_pkg::CFG_EXTRA_LEN:  xlen_q  <= cfg_data_i[4:0];
        default: ;  // unmapped index, ignored
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Input register stage
  // ---------------------------------------------------------------------------
  logic       s1_valid_q;
  logic [7:0] s1_byte_q;
  logic       s1_last_q;
  logic       out_valid_q;
  logic       found_out_q;
  logic       advance;
  logic       in_fire;

  // s1 moves on unless a finished result is stuck at the output
  assign advance    = s1_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o = s1_valid_q && !advance;
  assign in_fire    = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_fire) begin
      s1_valid_q <= 1'b1;
    end else if (advance) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_byte_q <= text_byte_i;
      s1_last_q <= last_byte_i;
    end
  end

  // ---------------------------------------------------------------------------
  // Byte window: entry 0 newest. Unused entries hold zero, and no keyword
  // contains a zero byte, so no separate fill count is needed.
  // ---------------------------------------------------------------------------
  logic [7:0] win_q [WINDOW_BYTES];
  logic [7:0] win_d [WINDOW_BYTES];
  logic       found_q;
  logic       hit;

  always_comb begin
    win_d[0] = s1_byte_q;
    for (int j = 1; j < WINDOW_BYTES; j++) begin
      win_d[j] = win_q[j-1];
    end
  end

  // Comparison view of the window padded to the longest keyword; entries past
  // the window read zero, so a keyword longer than the window never matches.
  logic [7:0] pad  [XMAX];
  logic [7:0] padf [XMAX];

  for (genvar j = 0; j < XMAX; j++) begin : g_pad
    if (j < WINDOW_BYTES) begin : g_in
      assign pad[j] = win_d[j];
    end else begin : g_out
      assign pad[j] = '0;
    end
    assign padf[j] = fold_byte(pad[j]);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int j = 0; j < WINDOW_BYTES; j++) begin
        win_q[j] <= '0;
      end
      found_q <= 1'b0;
    end else if (advance) begin
      if (s1_last_q) begin
        // message done: start the next one from an empty window
        for (int j = 0; j < WINDOW_BYTES; j++) begin
          win_q[j] <= '0;
        end
        found_q <= 1'b0;
      end else begin
        win_q   <= win_d;
        found_q <= found_q | hit;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Fixed keywords: each checked as ending on the newest byte.
  // ---------------------------------------------------------------------------
  logic fixed_hit;

  always_comb begin
    logic       ok;
    logic [7:0] a;
    fixed_hit = 1'b0;
    for (int k = 0; k < FCNT; k++) begin
      ok = 1'b1;
      for (int i = 0; i < FMAX; i++) begin
        if (i < int'(ksu_pkg::FIXED_LENS[k])) begin
          a = ksu_pkg::FIXED_FOLD[k] ? padf[int'(ksu_pkg::FIXED_LENS[k]) - 1 - i]
                                     : pad[int'(ksu_pkg::FIXED_LENS[k]) - 1 - i];
          if (a != ksu_pkg::FIXED_WORDS[k][8*i +: 8]) ok = 1'b0;
        end
      end
      fixed_hit = fixed_hit | ok;
    end
  end

  // ---------------------------------------------------------------------------
  // Extra keyword: effective length stops at the first zero byte and at 16.
  // Any byte within the effective length with bit 7 set turns case folding off.
  // ---------------------------------------------------------------------------
  logic [XMAX*8-1:0] xword;
  logic [7:0]        xw  [XMAX];
  logic [7:0]        xwf [XMAX];
  logic [4:0]        len_c;
  logic [4:0]        xeff;
  logic              xfold;

  assign xword = {xhigh_q, xlow_q};
  assign len_c = (xlen_q > 5'(XMAX)) ? 5'(XMAX) : xlen_q;

  always_comb begin
    logic stop;
    stop  = 1'b0;
    xeff  = '0;
    xfold = 1'b1;
    for (int i = 0; i < XMAX; i++) begin
      xw[i]  = xword[8*i +: 8];
      xwf[i] = fold_byte(xw[i]);
      if (!stop && (5'(i) < len_c) && (xw[i] != 8'h00)) begin
        xeff = xeff + 5'd1;
        if (xw[i][7]) xfold = 1'b0;
      end else begin
        stop = 1'b1;
      end
    end
  end

  // Match for every candidate length, then pick the effective one.
  logic [XMAX:0] xlen_hit;
  logic          extra_hit;

  always_comb begin
    logic       ok;
    logic [7:0] a;
    logic [7:0] b;
    xlen_hit[0] = 1'b0;  // empty keyword is disabled
    for (int l = 1; l <= XMAX; l++) begin
      ok = 1'b1;
      for (int i = 0; i < XMAX; i++) begin
        if (i < l) begin
          a = xfold ? padf[l - 1 - i] : pad[l - 1 - i];
          b = xfold ? xwf[i] : xw[i];
          if (a != b) ok = 1'b0;
        end
      end
      xlen_hit[l] = ok;
    end
  end

  assign extra_hit = xlen_hit[xeff];
  assign hit       = fixed_hit | extra_hit;

  // ---------------------------------------------------------------------------
  // Result register: one beat per message, on its last byte.
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance && s1_last_q) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && s1_last_q) begin
      found_out_q <= found_q | hit;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign keyword_found_o = found_out_q;

endmodule

[rtl/ksu_checker.sv]
// ksu_checker: port-level assertions for keyword_spotter_unit.
// Bound to the top level below; no package dependency.
module ksu_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid_i,
  input logic       in_stall_o,
  input logic       last_byte_i,
  input logic       out_valid_o,
  input logic       out_stall_i,
  input logic       keyword_found_o
);

  // a stalled result beat stays put
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(keyword_found_o))
    else $error("result beat changed while stalled");

  // input only backs up behind a stalled result
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o && out_stall_i)
    else $error("input stalled without a stalled result");

  // an accepted last byte yields a result once the output is free to take it
  a_last_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o && last_byte_i) ##1 (!out_valid_o || !out_stall_i)
      |=> out_valid_o)
    else $error("missing result for last byte");

  // no byte offered and output free: no new result follows
  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!in_valid_i && !in_stall_o) ##1 (!out_valid_o || !out_stall_i)
      |=> !out_valid_o)
    else $error("result beat without a pending byte");

endmodule

bind keyword_spotter_unit ksu_checker u_ksu_checker (.*);

[tb/keyword_spotter_unit_test.sv]
// Self-checking testbench for keyword_spotter_unit: byte stream in, one verdict per message out.
// Depends on ksu_pkg for register indexes and ASCII constants, and on the RTL top only.
// Keyword matching is predicted in place; results are checked in order against the prediction.
module keyword_spotter_unit_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int WINDOW       = 16;      // window depth the DUT is built with
  localparam int IDLE_PCT     = 18;      // chance per cycle that a side idles
  localparam int RANDOM_BYTES = 1200;    // random stimulus, split over the phases
  localparam int PHASES       = 8;       // extra-keyword settings walked through
  localparam int DRAIN_CYCLES = 4;       // drain margin after the last verdict
  localparam int CYCLE_LIMIT  = 200000;  // far above the slowest legal run

  localparam logic [7:0] ASCII_LOWER_A = ksu_pkg::ASCII_UPPER_A | ksu_pkg::ASCII_CASE;
  localparam logic [7:0] ASCII_LOWER_Z = ksu_pkg::ASCII_UPPER_Z | ksu_pkg::ASCII_CASE;

  typedef logic [7:0] byte_q_t [$];

  // Directed probes: whole messages. verdict < 0 means "ask the predictor".
  typedef struct {
    string text;
    int    verdict;
  } probe_t;

  // ---------------------------------------------------------------------------
  // DUT signals; every input starts at a known value
  // ---------------------------------------------------------------------------
  logic        clk_i       = 1'b0;
  logic        rst_ni      = 1'b0;
  logic        in_valid_i  = 1'b0;
  logic        in_stall_o;
  logic [7:0]  text_byte_i = 8'h00;
  logic        last_byte_i = 1'b0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic        keyword_found_o;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [1:0]  cfg_index_i = ksu_pkg::CFG_EXTRA_LOW;
  logic [63:0] cfg_data_i  = '0;

  keyword_spotter_unit #(
    .WINDOW_BYTES(WINDOW)
  ) dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .text_byte_i    (text_byte_i),
    .last_byte_i    (last_byte_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .keyword_found_o(keyword_found_o),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i)
  );

  // 8 ns period, rising edges at 4, 12, 20, ...
  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Keyword predictor: own copy of the window, match flag and extra keyword regs
  // ---------------------------------------------------------------------------
  logic [7:0]  win_bytes [WINDOW];   // newest byte in entry 0
  int unsigned win_fill;             // valid bytes in the window, saturates
  bit          msg_hit;              // some keyword seen in the current message
  logic [63:0] xw_low, xw_high;
  logic [4:0]  xw_len;
  byte_q_t     keyword_bytes [10];   // fixed keyword table, filled at start

  // Expected keyword_found per message, oldest first
  bit          verdict_q [$];

  int fail_count;
  int bytes_sent;
  int messages_checked;
  int hits_seen;
  bit calm;                          // set: neither side idles

  function automatic byte_q_t text_bytes(string s);
    byte_q_t q;
    for (int i = 0; i < s.len(); i++) q.push_back(s[i]);
    return q;
  endfunction

  function automatic logic [7:0] to_lower(logic [7:0] c);
    if (c >= ksu_pkg::ASCII_UPPER_A && c <= ksu_pkg::ASCII_UPPER_Z) begin
      return c | ksu_pkg::ASCII_CASE;
    end
    return c;
  endfunction

  function automatic bit is_letter(logic [7:0] c);
    return to_lower(c) >= ASCII_LOWER_A && to_lower(c) <= ASCII_LOWER_Z;
  endfunction

  // Extra keyword as programmed: length clipped to 16, cut at the first zero byte
  function automatic byte_q_t extra_keyword();
    byte_q_t    w;
    int         n;
    logic [7:0] b;
    n = (xw_len > ksu_pkg::EXTRA_MAX) ? ksu_pkg::EXTRA_MAX : int'(xw_len);
    for (int i = 0; i < n; i++) begin
      b = (i < 8) ? xw_low[8*i +: 8] : xw_high[8*(i-8) +: 8];
      if (b == 8'h00) break;
      w.push_back(b);
    end
    return w;
  endfunction

  // Does word w end at the newest window byte? Pure-ASCII words fold case.
  function automatic bit ends_at_newest(byte_q_t w);
    bit         fold;
    logic [7:0] a, b;
    fold = 1'b1;
    if (w.size() == 0 || w.size() > WINDOW || w.size() > win_fill) return 1'b0;
    foreach (w[i]) if (w[i][7]) fold = 1'b0;
    foreach (w[i]) begin
      a = win_bytes[w.size() - 1 - i];
      b = w[i];
      if (fold) begin
        a = to_lower(a);
        b = to_lower(b);
      end
      if (a != b) return 1'b0;
    end
    return 1'b1;
  endfunction

  // Shift one byte in and update the hit flag; returns 1 when a verdict is due.
  function automatic bit shift_and_spot(input logic [7:0] b, input bit last,
                                        output bit found);
    for (int i = WINDOW - 1; i > 0; i--) win_bytes[i] = win_bytes[i-1];
    win_bytes[0] = b;
    if (win_fill < WINDOW) win_fill++;
    foreach (keyword_bytes[k]) if (ends_at_newest(keyword_bytes[k])) msg_hit = 1'b1;
    if (ends_at_newest(extra_keyword())) msg_hit = 1'b1;
    found = msg_hit;
    if (last) begin
      foreach (win_bytes[i]) win_bytes[i] = 8'h00;
      win_fill = 0;
      msg_hit  = 1'b0;
    end
    return last;
  endfunction

  // ---------------------------------------------------------------------------
  // Result side: random stall, in-order compare against the verdict queue
  // ---------------------------------------------------------------------------
  always @(negedge clk_i) begin
    out_stall_i <= !calm && ($urandom_range(0, 99) < IDLE_PCT);
  end

  always @(posedge clk_i) begin
    bit want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (verdict_q.size() == 0) begin
        $error("result beat with no message pending: keyword_found=%0b", keyword_found_o);
        fail_count++;
      end else begin
        want = verdict_q.pop_front();
        messages_checked++;
        if (want) hits_seen++;
        if (keyword_found_o !== want) begin
          $error("keyword_found mismatch: expected %0b, actual %0b", want, keyword_found_o);
          fail_count++;
        end
      end
    end
  end

  // Watchdog
  int cycle_count;
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $error("timeout after %0d cycles, %0d verdicts outstanding",
             cycle_count, verdict_q.size());
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Byte side. Tasks start and end on a falling edge.
  // ---------------------------------------------------------------------------
  // One beat; valid stays up into the next beat unless an idle cycle intervenes.
  task automatic send_byte(input logic [7:0] b, input bit last, input int verdict);
    bit found;
    while (!calm && $urandom_range(0, 99) < IDLE_PCT) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i  <= 1'b1;
    text_byte_i <= b;
    last_byte_i <= last;
    do @(posedge clk_i); while (in_stall_o);
    if (shift_and_spot(b, last, found)) verdict_q.push_back(verdict >= 0 ? verdict[0] : found);
    bytes_sent++;
    @(negedge clk_i);
  endtask

  task automatic send_message(input byte_q_t msg, input int verdict);
    foreach (msg[i]) send_byte(msg[i], i == msg.size() - 1, verdict);
  endtask

  // Drop valid, wait for every verdict, then let the pipe drain: a non-last
  // byte leaves no verdict behind but may still be in flight.
  task automatic settle();
    in_valid_i <= 1'b0;
    while (verdict_q.size() != 0) @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(negedge clk_i);
  endtask

  // Caller lowers cfg_valid_i after the last write so valid is set once per step.
  task automatic write_reg(input logic [1:0] idx, input logic [63:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      ksu_pkg::CFG_EXTRA_LOW:  xw_low  = data;
      ksu_pkg::CFG_EXTRA_HIGH: xw_high = data;
      ksu_pkg::CFG_EXTRA_LEN:  xw_len  = data[4:0];
      default: ;
    endcase
    @(negedge clk_i);
  endtask

  task automatic load_extra_word(input logic [63:0] lo, input logic [63:0] hi,
                                 input logic [4:0] len);
    settle();
    write_reg(ksu_pkg::CFG_EXTRA_LOW, lo);
    write_reg(ksu_pkg::CFG_EXTRA_HIGH, hi);
    write_reg(ksu_pkg::CFG_EXTRA_LEN, 64'(len));
    cfg_valid_i <= 1'b0;
  endtask

  // Mostly letters of either case so keywords show up by chance too
  function automatic logic [7:0] filler_byte();
    logic [7:0] c;
    if ($urandom_range(0, 1)) begin
      c = ASCII_LOWER_A + 8'($urandom_range(0, 25));
      if ($urandom_range(0, 1)) c = c & ~ksu_pkg::ASCII_CASE;
    end else begin
      c = 8'($urandom_range(1, 255));
    end
    return c;
  endfunction

  // Eight bytes of keyword material: letters, optionally mixed with high bytes
  function automatic logic [63:0] word_bits(bit high_ok);
    logic [63:0] w;
    for (int i = 0; i < 8; i++) begin
      w[8*i +: 8] = ASCII_LOWER_A + 8'($urandom_range(0, 25));
      if ($urandom_range(0, 1)) w[8*i +: 8] = w[8*i +: 8] & ~ksu_pkg::ASCII_CASE;
      if (high_ok && $urandom_range(0, 1)) w[8*i +: 8] = 8'($urandom_range(128, 255));
    end
    return w;
  endfunction

  // Most messages carry a keyword (fixed or extra), case shuffled, some of them
  // damaged into near misses; the rest are plain noise, some longer than the window.
  task automatic send_random_message();
    byte_q_t msg, word;
    int      kind, pos;
    kind = $urandom_range(0, 99);
    repeat ($urandom_range(0, 6)) msg.push_back(filler_byte());
    if (kind < 70) begin
      word = keyword_bytes[$urandom_range(0, 9)];
      if ($urandom_range(0, 2) == 0 && extra_keyword().size() != 0) word = extra_keyword();
      foreach (word[i]) begin
        if (is_letter(word[i]) && $urandom_range(0, 1)) word[i] ^= ksu_pkg::ASCII_CASE;
      end
      if (kind < 20) begin
        pos = $urandom_range(0, word.size() - 1);
        if ($urandom_range(0, 1)) word.delete(pos);
        else word[pos] = 8'($urandom_range(1, 255));
      end
      foreach (word[i]) msg.push_back(word[i]);
    end else if (kind < 85) begin
      repeat ($urandom_range(WINDOW + 1, 40)) msg.push_back(filler_byte());
    end
    repeat ($urandom_range(0, 5)) msg.push_back(filler_byte());
    if (msg.size() == 0) msg.push_back(filler_byte());
    send_message(msg, -1);
  endtask

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  // After reset the extra keyword is disabled, so these verdicts are obvious;
  // the byte extremes, folded ASCII and an exact CJK keyword are covered.
  probe_t probes [7] = '{
    '{"\001",                              0},
    '{"\377",                              0},
    '{"OTP",                               1},
    '{"xPin",                             -1},
    '{"cod",                               0},
    '{"a\377Z",                           -1},
    '{"\351\252\214\350\257\201\347\240\201", 1}
  };

  initial begin
    logic [63:0] lo, hi;
    logic [4:0]  len;

    keyword_bytes[0] = text_bytes("code");
    keyword_bytes[1] = text_bytes("otp");
    keyword_bytes[2] = text_bytes("verify");
    keyword_bytes[3] = text_bytes("verification");
    keyword_bytes[4] = text_bytes("pin");
    keyword_bytes[5] = text_bytes("password");
    keyword_bytes[6] = text_bytes("passwd");
    keyword_bytes[7] = text_bytes("\351\252\214\350\257\201\347\240\201");
    keyword_bytes[8] = text_bytes("\346\240\241\351\252\214\347\240\201");
    keyword_bytes[9] = text_bytes("\345\212\250\346\200\201\347\240\201");
    foreach (win_bytes[i]) win_bytes[i] = 8'h00;
    win_fill = 0;
    msg_hit  = 1'b0;
    xw_low   = '0;
    xw_high  = '0;
    xw_len   = '0;
    calm     = 1'b0;

    repeat (10) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    foreach (probes[p]) send_message(text_bytes(probes[p].text), probes[p].verdict);

    // Each phase programs a new extra keyword, then streams random messages.
    for (int ph = 0; ph < PHASES; ph++) begin
      case (ph)
        0: begin  // explicit disable, all-zero data
          lo = '0; hi = '0; len = 5'd0;
        end
        1: begin  // short ASCII word, case-insensitive
          lo = word_bits(1'b0); hi = word_bits(1'b0); len = 5'($urandom_range(1, 8));
        end
        2: begin  // ASCII word spilling into the high register
          lo = word_bits(1'b0); hi = word_bits(1'b0); len = 5'($urandom_range(9, 16));
        end
        3: begin  // full-length word with high bytes: exact match
          lo = word_bits(1'b1); hi = word_bits(1'b1); len = 5'd16;
        end
        4: begin  // length beyond sixteen is clipped
          lo = word_bits(1'b0); hi = word_bits(1'b0); len = 5'd31;
        end
        5: begin  // zero byte in the low register cuts the word short if within len
          lo = word_bits(1'b0); hi = word_bits(1'b0); len = 5'($urandom_range(3, 16));
          lo[8*$urandom_range(1, 7) +: 8] = 8'h00;
        end
        6: begin  // all ones
          lo = '1; hi = '1; len = 5'd16;
        end
        default: begin
          lo = {$urandom, $urandom}; hi = {$urandom, $urandom};
          len = 5'($urandom_range(0, 16));
        end
      endcase
      load_extra_word(lo, hi, len);
      calm = (ph == 3);  // one long stretch with both sides always ready
      // The word from phase 1 may be as short as one letter and hit often;
      // every phase just runs its share of the byte budget.
      while (bytes_sent < (ph + 1) * (RANDOM_BYTES / PHASES)) send_random_message();
      calm = 1'b0;
    end

    settle();
    $display("Streamed %0d bytes in %0d checked messages (%0d with a keyword hit)",
             bytes_sent, messages_checked, hits_seen);
    $display("over %0d extra-keyword settings incl. disabled, clipped, zero-cut, all-ones",
             PHASES);
    if (fail_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

[filelist.f]
rtl/ksu_pkg.sv
rtl/keyword_spotter_unit.sv
rtl/ksu_checker.sv
tb/keyword_spotter_unit_test.sv
